// ===== rtl/cst_pkg.sv =====
// Package for the counted set table: item types, operation codes and defaults.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cst_pkg;

  // Default sizes of the table.
  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned KEY_WIDTH_DEF   = 32;

  // Operation codes carried in an input item.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } cst_op_e;

  // Status codes of a result item.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One input item.
  typedef struct packed {
    cst_op_e     operation;
    logic [31:0] key;
    logic [31:0] amount;
  } cst_in_t;

  // One result item.
  typedef struct packed {
    logic        status;
    logic [31:0] key_count;
    logic        present;
    logic [6:0]  distinct_keys;
    logic [6:0]  slots_used;
  } cst_out_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic capture;    // register the key compare
    logic write_hit;  // matching cell takes the new count
    logic alloc;      // first free cell takes key and new count
    logic clear;      // every cell zeroes its count
  } cst_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/cst_cell.sv =====
// One slot of the counted set table: key, count and an assigned flag.
// Depends on cst_pkg for the control struct.
`default_nettype none

module cst_cell #(
  parameter int unsigned KeyWidth   = cst_pkg::KEY_WIDTH_DEF,
  parameter int unsigned CountWidth = cst_pkg::COUNT_WIDTH_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  cst_pkg::cst_cell_ctrl_t    ctrl_i,
  input  wire logic [KeyWidth-1:0]   key_i,
  input  wire logic [CountWidth-1:0] count_i,
  input  wire logic                  prev_valid_i,
  output logic                       valid_o,
  output logic                       hit_o,
  output logic [CountWidth-1:0]      count_o
);

  logic                  valid_q, valid_d;
  logic                  match_q, match_d;
  logic [KeyWidth-1:0]   key_q, key_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic                  is_next_free;

  // Slots fill in order, so the first free cell is the one whose left
  // neighbor is assigned while it is not.
  assign is_next_free = prev_valid_i & ~valid_q;
  assign hit_o        = valid_q & (key_q == key_i);

  always_comb begin
    valid_d = valid_q;
    match_d = match_q;
    key_d   = key_q;
    count_d = count_q;
    if (ctrl_i.capture) begin
      match_d = hit_o;
    end
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.write_hit && match_q) begin
      count_d = count_i;
    end else if (ctrl_i.alloc && is_next_free) begin
      valid_d = 1'b1;
      key_d   = key_i;
      count_d = count_i;
    end
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // Slot contents.
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    count_q <= count_d;
  end

  assign valid_o = valid_q;
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== rtl/counted_set_table_unit.sv =====
// Top level of the counted set table: command sequencer and a row of slot cells.
// Depends on cst_pkg and cst_cell.
//
//   Channel  | Direction | Handshake                       | Payload
//   ---------+-----------+---------------------------------+-----------------------
//   command  | in        | start & !busy at rising edge    | cmd_i    (cst_in_t)
//   result   | out       | result_valid_o for one cycle    | result_o (cst_out_t)
//
// An item goes through a compare state, to match its key against every cell and
// pick the matching count, then an update state, to update the count in the cell
// and present the result. busy is high only in the compare cycle, so a new item
// may be taken at the edge that ends the result cycle. Reset empties the table
// at once. The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module counted_set_table_unit #(
  parameter int unsigned Capacity   = cst_pkg::CAPACITY_DEF,
  parameter int unsigned CountWidth = cst_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned KeyWidth   = cst_pkg::KEY_WIDTH_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  cst_pkg::cst_in_t     cmd_i,
  output logic                 result_valid_o,
  output cst_pkg::cst_out_t    result_o
);

  localparam int unsigned CntWidth = $clog2(Capacity + 1);
  localparam int unsigned SumWidth = ((CountWidth > 32) ? CountWidth : 32) + 1;
  localparam logic [CountWidth-1:0] CountMax = '1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCmp  = 2'd1;
  localparam logic [1:0] StUpd  = 2'd2;

  logic [1:0]            state_q, state_d;
  cst_pkg::cst_op_e      op_q;
  logic [KeyWidth-1:0]   key_q, key_d;
  logic [31:0]           amt_q;
  logic                  hit_q, hit_d;
  logic [CountWidth-1:0] old_q, old_d;
  logic [CntWidth-1:0]   used_q, used_d;
  logic [CntWidth-1:0]   dist_q, dist_d;

  logic                  accept;
  logic [KeyWidth+31:0]  key_ext;
  cst_pkg::cst_cell_ctrl_t ctrl;
  logic [CountWidth-1:0] new_count;
  logic [Capacity:0]     valid_chain;
  logic [Capacity-1:0]   cell_hit;
  logic [CountWidth-1:0] cell_count [Capacity];

  logic [SumWidth-1:0]   sum;
  logic [CountWidth-1:0] sat_count;
  logic                  table_full;
  logic                  new_key;
  logic                  do_alloc;
  logic                  status;
  logic [CountWidth-1:0] res_count;
  logic [CountWidth+31:0] res_count_ext;
  logic [CntWidth+6:0]   dist_ext;
  logic [CntWidth+6:0]   used_ext;

  assign accept  = start & ~busy;
  assign busy    = (state_q == StCmp);
  assign key_ext = {{KeyWidth{1'b0}}, cmd_i.key};
  assign key_d   = key_ext[KeyWidth-1:0];

  // Sequencer: idle, compare, update.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  state_d = accept ? StCmp : StIdle;
      StCmp:   state_d = StUpd;
      StUpd:   state_d = accept ? StCmp : StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Row of slot cells; the assigned flag passes from each cell to the next.
  assign valid_chain[0] = 1'b1;
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    cst_cell #(
      .KeyWidth   (KeyWidth),
      .CountWidth (CountWidth)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (key_q),
      .count_i      (new_count),
      .prev_valid_i (valid_chain[i]),
      .valid_o      (valid_chain[i+1]),
      .hit_o        (cell_hit[i]),
      .count_o      (cell_count[i])
    );
  end

  // Pick the count of the matching cell; keys are unique, so at most one hits.
  always_comb begin
    old_d = '0;
    for (int i = 0; i < Capacity; i++) begin
      old_d = old_d | (cell_count[i] & {CountWidth{cell_hit[i]}});
    end
    hit_d = |cell_hit;
  end

  // Saturating add of the amount to the old count.
  assign sum       = SumWidth'(old_q) + SumWidth'(amt_q);
  assign sat_count = (|sum[SumWidth-1:CountWidth]) ? CountMax : sum[CountWidth-1:0];

  // Update decisions in the result cycle.
  assign table_full = (used_q == CntWidth'(Capacity));
  assign new_key    = (op_q == cst_pkg::OP_ADD) && (amt_q != 32'd0) && !hit_q;
  assign do_alloc   = new_key && !table_full;
  assign status     = (new_key && table_full) ? cst_pkg::STATUS_FULL : cst_pkg::STATUS_OK;

  always_comb begin
    ctrl      = '0;
    new_count = '0;
    res_count = '0;
    used_d    = used_q;
    dist_d    = dist_q;
    ctrl.capture = (state_q == StCmp);
    if (state_q == StUpd) begin
      case (op_q)
        cst_pkg::OP_ADD: begin
          new_count      = sat_count;
          ctrl.write_hit = hit_q;
          ctrl.alloc     = do_alloc;
          if (do_alloc) begin
            used_d = used_q + CntWidth'(1);
          end
          if (hit_q || do_alloc) begin
            res_count = sat_count;
            if ((old_q == '0) && (sat_count != '0)) begin
              dist_d = dist_q + CntWidth'(1);
            end
          end
        end
        cst_pkg::OP_REMOVE: begin
          ctrl.write_hit = hit_q;
          if (hit_q && (old_q != '0) && (dist_q != '0)) begin
            dist_d = dist_q - CntWidth'(1);
          end
        end
        cst_pkg::OP_QUERY: begin
          res_count = old_q;
        end
        default: begin
          ctrl.clear = 1'b1;
          dist_d     = '0;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      used_q  <= '0;
      dist_q  <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      dist_q  <= dist_d;
      if (state_q == StCmp) begin
        hit_q <= hit_d;
      end
    end
  end

  // Item payload and the picked count.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= cmd_i.operation;
      key_q <= key_d;
      amt_q <= cmd_i.amount;
    end
    if (state_q == StCmp) begin
      old_q <= old_d;
    end
  end

  // Result item.
  assign res_count_ext = {32'd0, res_count};
  assign dist_ext      = {7'd0, dist_d};
  assign used_ext      = {7'd0, used_d};

  assign result_valid_o         = (state_q == StUpd);
  assign result_o.status        = status;
  assign result_o.key_count     = res_count_ext[31:0];
  assign result_o.present       = (res_count != '0);
  assign result_o.distinct_keys = dist_ext[6:0];
  assign result_o.slots_used    = used_ext[6:0];

endmodule

`default_nettype wire

// ===== rtl/cst_checker.sv =====
// Port-level checks of the counted set table, bound to the top level.
// Depends on cst_pkg and counted_set_table_unit.
`default_nettype none

module cst_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire logic         start,
  input wire logic         busy,
  input wire logic         result_valid_o,
  input cst_pkg::cst_out_t result_o
);

  // A taken item occupies the compare cycle next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item taken without entering the compare cycle");

  // The compare cycle is always followed by exactly one result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (result_valid_o && !busy))
    else $error("compare cycle not followed by a result");

  // No result appears without a compare cycle before it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a preceding item");

  // A full-table answer carries no count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status == cst_pkg::STATUS_FULL)) |->
      ((result_o.key_count == 32'd0) && !result_o.present))
    else $error("table-full result reports a count");

endmodule

bind counted_set_table_unit cst_checker u_cst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

`default_nettype wire
